>>> design/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and codes of the page table walker
// Field codes, register indexes, architectural masks and the structures that
// pass between the front end, the word queue and the walk engine.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int VA_BITS         = 48;
   localparam int PA_BITS         = 52;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int QUEUE_DEPTH     = 4;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAGING_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ONE_GIB     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PHYS    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROOT        = 2'd3;

   localparam logic OP_TRANSLATE     = 1'b0;
   localparam logic OP_READ_RESPONSE = 1'b1;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   localparam logic [2:0] ST_TRANSLATED    = 3'd0;
   localparam logic [2:0] ST_NOT_CANONICAL = 3'd1;
   localparam logic [2:0] ST_NOT_PRESENT   = 3'd2;
   localparam logic [2:0] ST_RESERVED_BIT  = 3'd3;
   localparam logic [2:0] ST_READ_FAILED   = 3'd4;
   localparam logic [2:0] ST_UNSUPPORTED   = 3'd5;
   localparam logic [2:0] ST_SEQUENCE      = 3'd6;

   localparam logic [2:0] LEVEL_NONE = 3'd0;

   localparam logic [1:0] PAGE_4K = 2'd0;
   localparam logic [1:0] PAGE_2M = 2'd1;
   localparam logic [1:0] PAGE_1G = 2'd2;

   localparam logic [2:0] SOFT_NONE        = 3'd0;
   localparam logic [2:0] SOFT_ZERO        = 3'd1;
   localparam logic [2:0] SOFT_UNKNOWN     = 3'd2;
   localparam logic [2:0] SOFT_TRANSITION  = 3'd3;
   localparam logic [2:0] SOFT_PROTOTYPE   = 3'd4;
   localparam logic [2:0] SOFT_DEMAND_ZERO = 3'd5;
   localparam logic [2:0] SOFT_PAGE_FILE   = 3'd6;

   // Outcome of the checks on a translate request, settled in the front end.
   localparam logic [1:0] TC_OK          = 2'd0;
   localparam logic [1:0] TC_UNSUPPORTED = 2'd1;
   localparam logic [1:0] TC_NONCANON    = 2'd2;
   localparam logic [1:0] TC_ROOT_RSV    = 2'd3;

   localparam logic [1:0] LV_PML4 = 2'd0;
   localparam logic [1:0] LV_PDPT = 2'd1;
   localparam logic [1:0] LV_PD   = 2'd2;
   localparam logic [1:0] LV_PT   = 2'd3;

   localparam logic [63:0] ARCH_ADDR_MASK = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] RSV_LOW_1G     = 64'h0000_0000_3FFF_E000;
   localparam logic [63:0] RSV_LOW_2M     = 64'h0000_0000_001F_E000;
   localparam logic [63:0] PS_MASK        = 64'h0000_0000_0000_0080;
   localparam int          PS_BIT         = 7;
   localparam int          NX_BIT         = 63;

   // One classified word as it waits in the queue. For a read response, data
   // holds the entry; for a translate request it holds the reserved root bits.
   typedef struct packed {
      logic                is_resp;
      logic                read_ok;
      logic [1:0]          t_class;
      logic [2:0]          soft_kind;
      logic [63:0]         data;
      logic [VA_BITS-1:0]  va;
      logic [PA_BITS-1:0]  addr;
   } item_type;

   typedef struct packed {
      logic        one_gib;
      logic [63:0] phys_rsv;
   } cfg_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] level;
   } walk_type;

endpackage

>>> design/ptw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_req_if: request channel of the page table walker
// Carries translate requests and memory read responses with valid and ready.
// ----------------------------------------------------------------------------
interface ptw_req_if ();
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [63:0] virtual_address;
   logic [63:0] read_data;
   logic        read_ok;

   modport source (output valid, output opcode, output virtual_address,
                   output read_data, output read_ok, input ready);
   modport sink   (input valid, input opcode, input virtual_address,
                   input read_data, input read_ok, output ready);
endinterface

>>> design/ptw_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_rsp_if: result channel of the page table walker
// Carries read requests and final translation results with valid and ready.
// ----------------------------------------------------------------------------
interface ptw_rsp_if ();
   logic        valid;
   logic        ready;
   logic        kind;
   logic [51:0] address;
   logic [2:0]  status;
   logic [2:0]  failed_level;
   logic [63:0] reserved_bits;
   logic [1:0]  page_size;
   logic        writable;
   logic        user_accessible;
   logic        no_execute;
   logic [2:0]  soft_entry_kind;
   logic [3:0]  page_file_number;
   logic [31:0] page_file_offset;

   modport source (output valid, output kind, output address, output status,
                   output failed_level, output reserved_bits, output page_size,
                   output writable, output user_accessible, output no_execute,
                   output soft_entry_kind, output page_file_number,
                   output page_file_offset, input ready);
   modport sink   (input valid, input kind, input address, input status,
                   input failed_level, input reserved_bits, input page_size,
                   input writable, input user_accessible, input no_execute,
                   input soft_entry_kind, input page_file_number,
                   input page_file_offset, output ready);
endinterface

>>> design/ptw_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_csr_if: configuration write channel of the page table walker
// Carries a register index and write data with valid and ready.
// ----------------------------------------------------------------------------
interface ptw_csr_if import ptw_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [63:0]                write_data;

   modport source (output valid, output index, output write_data, input ready);
   modport sink   (input valid, input index, input write_data, output ready);
endinterface

>>> design/ptw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_front: request front end of the page table walker
// Holds the configuration registers, accepts request words and classifies
// them: mode, canonical and root checks for translates, software entry
// decode for read responses. Classified words go to the queue.
// ----------------------------------------------------------------------------
module ptw_front import ptw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ptw_req_if.sink  req_bus,
   ptw_csr_if.sink  csr_bus,
   input  logic     q_ready,
   output logic     q_push,
   output item_type q_item,
   output cfg_type  cfg
);

   logic        mode_ff, mode_in;
   logic        one_gib_ff, one_gib_in;
   logic [5:0]  max_bits_ff, max_bits_in;
   logic [63:0] root_ff, root_in;

   logic [5:0]  bits_eff;
   logic [63:0] phys_rsv;
   logic [63:0] root_rsv;
   logic        canonical;
   logic        trans_bit;
   logic        proto_bit;
   logic [63:0] raw;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      one_gib_in  = one_gib_ff;
      max_bits_in = max_bits_ff;
      root_in     = root_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PAGING_MODE: mode_in     = csr_bus.write_data[0];
            CSR_ONE_GIB:     one_gib_in  = csr_bus.write_data[0];
            CSR_MAX_PHYS:    max_bits_in = csr_bus.write_data[5:0];
            CSR_ROOT:        root_in     = csr_bus.write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b1;
         one_gib_ff  <= 1'b1;
         max_bits_ff <= 6'd0;
         root_ff     <= 64'd0;
      end else begin
         mode_ff     <= mode_in;
         one_gib_ff  <= one_gib_in;
         max_bits_ff <= max_bits_in;
         root_ff     <= root_in;
      end
   end

   // Address bits at or above MAXPHYADDR are reserved; zero turns the check off
   // and a width of 52 or more leaves nothing reserved.
   always_comb begin
      bits_eff = (max_bits_ff < 6'd12) ? 6'd12 : max_bits_ff;
      if (max_bits_ff == 6'd0 || bits_eff >= 6'd52) begin
         phys_rsv = 64'd0;
      end else begin
         phys_rsv = ARCH_ADDR_MASK & ({64{1'b1}} << bits_eff);
      end
   end

   assign cfg.one_gib  = one_gib_ff;
   assign cfg.phys_rsv = phys_rsv;

   assign req_bus.ready = q_ready;
   assign q_push        = req_bus.valid && q_ready;

   assign raw       = req_bus.read_data;
   assign root_rsv  = root_ff & phys_rsv;
   assign canonical = (&req_bus.virtual_address[63:VA_BITS-1])
                   || (~|req_bus.virtual_address[63:VA_BITS-1]);
   assign trans_bit = raw[11];
   assign proto_bit = raw[10];

   always_comb begin
      q_item.is_resp = (req_bus.opcode == OP_READ_RESPONSE);
      q_item.read_ok = req_bus.read_ok;
      q_item.va      = req_bus.virtual_address[VA_BITS-1:0];
      q_item.addr    = {root_ff[PA_BITS-1:12], req_bus.virtual_address[47:39], 3'b000};
      q_item.data    = q_item.is_resp ? raw : root_rsv;

      if (!mode_ff) begin
         q_item.t_class = TC_UNSUPPORTED;
      end else if (!canonical) begin
         q_item.t_class = TC_NONCANON;
      end else if (root_rsv != 64'd0) begin
         q_item.t_class = TC_ROOT_RSV;
      end else begin
         q_item.t_class = TC_OK;
      end

      // Software meaning of a not-present entry.
      if (raw == 64'd0) begin
         q_item.soft_kind = SOFT_ZERO;
      end else if (trans_bit && proto_bit) begin
         q_item.soft_kind = SOFT_UNKNOWN;
      end else if (trans_bit) begin
         q_item.soft_kind = SOFT_TRANSITION;
      end else if (proto_bit) begin
         q_item.soft_kind = SOFT_PROTOTYPE;
      end else if (raw[63:32] == 32'd0) begin
         q_item.soft_kind = SOFT_DEMAND_ZERO;
      end else begin
         q_item.soft_kind = SOFT_PAGE_FILE;
      end
   end

endmodule

>>> design/ptw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_queue: word queue between front end and walk engine
// A small register queue of classified words with a fill count.
// ----------------------------------------------------------------------------
module ptw_queue import ptw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     push_ready,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/ptw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_back: walk engine of the page table walker
// Takes one classified word per cycle unless the result channel stalls, keeps
// the walk state, checks each entry against the reserved bits of its level,
// merges permissions, registers the read request or final result on rsp_bus.
// ----------------------------------------------------------------------------
module ptw_back import ptw_pkg::*; #(
   parameter int PHYS_ADDR_WIDTH = 52
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   input  cfg_type    cfg,
   ptw_rsp_if.source  rsp_bus,
   output walk_type   walk
);

   localparam logic [PA_BITS-1:0] ADDR_LIMIT = {PA_BITS{1'b1}} >> (PA_BITS - PHYS_ADDR_WIDTH);

   typedef struct packed {
      logic                kind;
      logic [PA_BITS-1:0]  address;
      logic [2:0]          status;
      logic [2:0]          failed_level;
      logic [63:0]         reserved_bits;
      logic [1:0]          page_size;
      logic                writable;
      logic                user_accessible;
      logic                no_execute;
      logic [2:0]          soft_entry_kind;
      logic [3:0]          page_file_number;
      logic [31:0]         page_file_offset;
   } rsp_type;

   logic               busy_ff, busy_in;
   logic [1:0]         level_ff, level_in;
   logic [VA_BITS-1:0] va_ff, va_in;
   logic               w_ff, w_in;
   logic               u_ff, u_in;
   logic               nx_ff, nx_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [63:0]        raw;
   logic [2:0]         fail_lv;
   logic               big_page;
   logic [63:0]        mask;
   logic [63:0]        hit;
   logic               w_m, u_m, nx_m;
   logic [8:0]         next_idx;
   logic [PA_BITS-1:0] phys;
   logic [1:0]         size;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_bus.ready);

   assign raw      = q_item.data;
   assign fail_lv  = {1'b0, level_ff} + 3'd1;
   assign big_page = (level_ff == LV_PDPT || level_ff == LV_PD) && raw[PS_BIT];

   // Reserved bits of the entry at the current level.
   always_comb begin
      mask = cfg.phys_rsv;
      case (level_ff)
         LV_PML4: mask = mask | PS_MASK;
         LV_PDPT: begin
            if (!cfg.one_gib) begin
               mask = mask | PS_MASK;
            end else if (big_page) begin
               mask = mask | RSV_LOW_1G;
            end
         end
         LV_PD: begin
            if (big_page) begin
               mask = mask | RSV_LOW_2M;
            end
         end
         default: ;
      endcase
   end

   assign hit = raw & mask;

   // The first level starts the permission merge afresh.
   assign w_m  = (level_ff == LV_PML4) ? raw[1]      : (w_ff && raw[1]);
   assign u_m  = (level_ff == LV_PML4) ? raw[2]      : (u_ff && raw[2]);
   assign nx_m = (level_ff == LV_PML4) ? raw[NX_BIT] : (nx_ff || raw[NX_BIT]);

   always_comb begin
      case (level_ff)
         LV_PML4: next_idx = va_ff[38:30];
         LV_PDPT: next_idx = va_ff[29:21];
         default: next_idx = va_ff[20:12];
      endcase
   end

   always_comb begin
      if (!big_page) begin
         phys = {raw[PA_BITS-1:12], va_ff[11:0]};
         size = PAGE_4K;
      end else if (level_ff == LV_PDPT) begin
         phys = {raw[PA_BITS-1:30], va_ff[29:0]};
         size = PAGE_1G;
      end else begin
         phys = {raw[PA_BITS-1:21], va_ff[20:0]};
         size = PAGE_2M;
      end
   end

   always_comb begin
      rsp_in   = '0;
      busy_in  = busy_ff;
      level_in = level_ff;
      va_in    = va_ff;
      w_in     = w_ff;
      u_in     = u_ff;
      nx_in    = nx_ff;
      rsp_in.kind = KIND_FINAL;

      if (!q_item.is_resp) begin
         if (busy_ff) begin
            rsp_in.status = ST_SEQUENCE;
         end else begin
            case (q_item.t_class)
               TC_UNSUPPORTED: rsp_in.status = ST_UNSUPPORTED;
               TC_NONCANON:    rsp_in.status = ST_NOT_CANONICAL;
               TC_ROOT_RSV: begin
                  rsp_in.status        = ST_RESERVED_BIT;
                  rsp_in.reserved_bits = q_item.data;
               end
               default: begin
                  rsp_in.kind    = KIND_READ;
                  rsp_in.address = q_item.addr & ADDR_LIMIT;
                  busy_in        = 1'b1;
                  level_in       = LV_PML4;
                  va_in          = q_item.va;
               end
            endcase
         end
      end else if (!busy_ff) begin
         rsp_in.status = ST_SEQUENCE;
      end else if (!q_item.read_ok) begin
         rsp_in.status       = ST_READ_FAILED;
         rsp_in.failed_level = fail_lv;
         busy_in             = 1'b0;
      end else if (!raw[0]) begin
         rsp_in.status          = ST_NOT_PRESENT;
         rsp_in.failed_level    = fail_lv;
         rsp_in.soft_entry_kind = q_item.soft_kind;
         if (q_item.soft_kind == SOFT_PAGE_FILE) begin
            rsp_in.page_file_number = raw[4:1];
            rsp_in.page_file_offset = raw[63:32];
         end
         busy_in = 1'b0;
      end else if (hit != 64'd0) begin
         rsp_in.status        = ST_RESERVED_BIT;
         rsp_in.failed_level  = fail_lv;
         rsp_in.reserved_bits = hit;
         busy_in              = 1'b0;
      end else begin
         w_in  = w_m;
         u_in  = u_m;
         nx_in = nx_m;
         if (big_page || level_ff == LV_PT) begin
            rsp_in.status          = ST_TRANSLATED;
            rsp_in.failed_level    = LEVEL_NONE;
            rsp_in.address         = phys & ADDR_LIMIT;
            rsp_in.page_size       = size;
            rsp_in.writable        = w_m;
            rsp_in.user_accessible = u_m;
            rsp_in.no_execute      = nx_m;
            busy_in                = 1'b0;
         end else begin
            rsp_in.kind    = KIND_READ;
            rsp_in.address = {raw[PA_BITS-1:12], next_idx, 3'b000} & ADDR_LIMIT;
            level_in       = level_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= LV_PML4;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            busy_ff      <= busy_in;
            level_ff     <= level_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         va_ff  <= va_in;
         w_ff   <= w_in;
         u_ff   <= u_in;
         nx_ff  <= nx_in;
         rsp_ff <= rsp_in;
      end
   end

   assign walk.busy  = busy_ff;
   assign walk.level = level_ff;

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.kind             = rsp_ff.kind;
   assign rsp_bus.address          = rsp_ff.address;
   assign rsp_bus.status           = rsp_ff.status;
   assign rsp_bus.failed_level     = rsp_ff.failed_level;
   assign rsp_bus.reserved_bits    = rsp_ff.reserved_bits;
   assign rsp_bus.page_size        = rsp_ff.page_size;
   assign rsp_bus.writable         = rsp_ff.writable;
   assign rsp_bus.user_accessible  = rsp_ff.user_accessible;
   assign rsp_bus.no_execute       = rsp_ff.no_execute;
   assign rsp_bus.soft_entry_kind  = rsp_ff.soft_entry_kind;
   assign rsp_bus.page_file_number = rsp_ff.page_file_number;
   assign rsp_bus.page_file_offset = rsp_ff.page_file_offset;

endmodule

>>> design/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker: four-level page table walk engine
// Translates 48-bit canonical virtual addresses by issuing page table entry
// reads on the result channel and consuming the read responses.
// ----------------------------------------------------------------------------
// The walker takes one word per cycle on req_bus: a translate request or the
// memory response to the read it last asked for, and gives exactly one word
// on rsp_bus for each: the next entry read or the final result. A word is
// written into a four-word queue at the edge that accepts it, and the walk
// engine registers its result into the rsp_bus output register when it takes
// the word from the queue; the result waits there until rsp_bus takes it.
// The walk engine handles one level per word, which sets the sustained rate of
// one word per cycle while rsp_bus is not stalled; req_bus ready drops only
// once the queue fills while rsp_bus is stalled.
// Configuration writes are taken at any time on csr_bus and belong to idle
// periods; a full walk costs five words in and five out.
module four_level_page_table_walker import ptw_pkg::*; #(
   parameter int PHYS_ADDR_WIDTH = 52
) (
   input  logic       clock,
   input  logic       reset,
   ptw_req_if.sink    req_bus,
   ptw_rsp_if.source  rsp_bus,
   ptw_csr_if.sink    csr_bus
);

   logic     q_push;
   logic     q_ready;
   item_type q_in_item;
   logic     q_pop;
   logic     q_valid;
   item_type q_out_item;
   cfg_type  cfg;
   walk_type walk;

   ptw_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_item  (q_in_item),
      .cfg     (cfg)
   );

   ptw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_out_item)
   );

   ptw_back #(
      .PHYS_ADDR_WIDTH (PHYS_ADDR_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_out_item),
      .q_pop   (q_pop),
      .cfg     (cfg),
      .rsp_bus (rsp_bus),
      .walk    (walk)
   );

`ifndef ASSERT_OFF
   // A pending entry read always belongs to a walk in progress.
   a_read_needs_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_READ) |-> walk.busy)
      else $error("entry read shown with no walk in progress");

   // Translated, not-present and read-failed results leave the engine idle.
   a_final_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_FINAL &&
       (rsp_bus.status == ST_TRANSLATED || rsp_bus.status == ST_NOT_PRESENT ||
        rsp_bus.status == ST_READ_FAILED)) |-> !walk.busy)
      else $error("walk still busy after its final result");

   // Within one walk the level only steps down the tree one level at a time.
   a_level_steps: assert property (@(posedge clock) disable iff (reset)
      (walk.busy && $past(walk.busy) && walk.level != $past(walk.level))
      |-> (walk.level == $past(walk.level) + 2'd1))
      else $error("walk level skipped or went back");
`endif

endmodule
